// File: sv/mdp_pi_pkg.sv
`default_nettype none
package mdp_pi_pkg;

  localparam int NUM_STATES_DEF   = 16;
  localparam int NUM_ACTIONS_DEF  = 4;
  localparam int NUM_OUTCOMES_DEF = 3;
  localparam int VALUE_WIDTH_DEF  = 32;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SWEEPS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUNDS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STATES_IN_USE = 3'd4;

  localparam logic [15:0] DISCOUNT_RST      = 16'd64881;
  localparam logic [15:0] TOLERANCE_RST     = 16'd0;
  localparam logic [15:0] MAX_SWEEPS_RST    = 16'd4096;
  localparam logic [7:0]  MAX_ROUNDS_RST    = 8'd64;
  localparam logic [4:0]  STATES_IN_USE_RST = 5'd16;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SOLVE_INIT,
    OP_ROUND_INIT,
    OP_TREAD,
    OP_VREAD,
    OP_MUL,
    OP_INNER,
    OP_PMUL,
    OP_ACC,
    OP_PREAD,
    OP_EWRITE,
    OP_SWEEP,
    OP_IMPROVE,
    OP_POLWRITE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   eval;   // evaluation pass: follow policy, honor done flags
    logic   first;  // first sweep: previous values read as zero
    logic   bank;   // value bank holding previous values
    logic   slot0;  // accumulating outcome slot zero
    logic   last;   // final result of a solve
  } dp_cmd_t;

  typedef struct packed {
    logic big_gt_tol;
    logic stable;
  } dp_status_t;

endpackage
`default_nettype wire

// File: sv/mdp_pi_dp.sv
`default_nettype none
module mdp_pi_dp #(
  parameter int NUM_STATES   = 16,
  parameter int NUM_ACTIONS  = 4,
  parameter int NUM_OUTCOMES = 3,
  parameter int VALUE_WIDTH  = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mdp_pi_pkg::dp_cmd_t                cmd,
  input  wire logic [$clog2(NUM_STATES)-1:0]      s_idx,
  input  wire logic [$clog2(NUM_ACTIONS)-1:0]     a_idx,
  input  wire logic [((NUM_OUTCOMES > 1) ? $clog2(NUM_OUTCOMES) : 1)-1:0] o_idx,
  input  wire logic [$clog2(NUM_STATES+1)-1:0]    used,
  input  wire logic [15:0]                        discount,
  input  wire logic [15:0]                        tolerance,
  input  wire logic [3:0]                         in_state_index,
  input  wire logic [1:0]                         in_action_index,
  input  wire logic [1:0]                         in_outcome_slot,
  input  wire logic [3:0]                         in_next_state,
  input  wire logic signed [15:0]                 in_reward,
  input  wire logic [16:0]                        in_probability,
  input  wire logic                               in_terminal,
  output mdp_pi_pkg::dp_status_t                  status,
  output logic                                    out_valid,
  output logic [3:0]                              out_state,
  output logic [1:0]                              out_best_action,
  output logic                                    out_stable,
  output logic                                    out_last
);
  import mdp_pi_pkg::*;

  localparam int SW   = $clog2(NUM_STATES);
  localparam int AW   = $clog2(NUM_ACTIONS);
  localparam int UW   = $clog2(NUM_STATES+1);
  localparam int TSZ  = NUM_STATES * NUM_ACTIONS * NUM_OUTCOMES;
  localparam int TW   = $clog2(TSZ);
  localparam int VW   = VALUE_WIDTH;
  localparam int PW   = VW + 17;
  localparam int IPW  = VW + 6;
  localparam int ACW  = VW + 6;

  typedef struct packed {
    logic [3:0]         next;
    logic signed [15:0] reward;
    logic [16:0]        prob;
    logic               done;
  } entry_t;

  entry_t             tab_mem [TSZ];
  logic [TSZ-1:0]     vld_r;
  entry_t             ent_raw_r;
  logic               ent_vld_r;
  entry_t             ent;

  logic signed [VW-1:0] val_mem [2][NUM_STATES];
  logic signed [VW-1:0] vrd_r;
  logic                 zero_r;
  logic signed [VW-1:0] nv;

  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  gsum;
  logic signed [VW:0]    g;
  logic signed [IPW-1:0] inner_pre;
  logic signed [VW-1:0]  inner_sat;
  logic signed [VW-1:0]  inner_r;
  logic signed [PW-1:0]  frac_r;
  logic                  pint_r;
  logic signed [PW-1:0]  rsum;
  logic signed [ACW-1:0] term;
  logic signed [ACW-1:0] acc_r;
  logic signed [VW-1:0]  q;

  logic signed [VW:0]    diff;
  logic [VW:0]           absd;
  logic [VW:0]           big_r;

  logic signed [VW-1:0]  best_q_r;
  logic [AW-1:0]         best_a_r;
  logic [AW-1:0]         pol_r [NUM_STATES];
  logic                  stable_r;

  logic [TW-1:0]         ld_idx;
  logic                  ld_ok;
  entry_t                ld_ent;
  logic [AW-1:0]         act;
  logic [TW-1:0]         rd_idx;
  logic [SW-1:0]         vaddr;

  // Load addressing; out-of-range fields drop the beat
  assign ld_ok  = (32'(in_state_index) < NUM_STATES) && (32'(in_action_index) < NUM_ACTIONS)
               && (32'(in_outcome_slot) < NUM_OUTCOMES);
  assign ld_idx = TW'((32'(in_state_index) * NUM_ACTIONS + 32'(in_action_index))
               * NUM_OUTCOMES + 32'(in_outcome_slot));
  assign ld_ent = '{next: in_next_state, reward: in_reward, prob: in_probability,
                    done: in_terminal};

  assign act    = cmd.eval ? pol_r[s_idx] : a_idx;
  assign rd_idx = TW'((32'(s_idx) * NUM_ACTIONS + 32'(act)) * NUM_OUTCOMES + 32'(o_idx));
  assign ent    = ent_vld_r ? ent_raw_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && ld_ok) begin
      tab_mem[ld_idx] <= ld_ent;
    end
    if (cmd.op == OP_TREAD) begin
      ent_raw_r <= tab_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      ent_vld_r <= 1'b0;
    end else begin
      if (cmd.op == OP_LOAD && ld_ok) begin
        vld_r[ld_idx] <= 1'b1;
      end
      if (cmd.op == OP_TREAD) begin
        ent_vld_r <= vld_r[rd_idx];
      end
    end
  end

  // Value banks: read previous, write current
  assign vaddr = (cmd.op == OP_VREAD) ? SW'(ent.next) : s_idx;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_VREAD || cmd.op == OP_PREAD) begin
      vrd_r <= val_mem[cmd.bank][vaddr];
    end
    if (cmd.op == OP_VREAD) begin
      zero_r <= cmd.first || (32'(ent.next) >= 32'(used));
    end else if (cmd.op == OP_PREAD) begin
      zero_r <= cmd.first;
    end
    if (cmd.op == OP_EWRITE) begin
      val_mem[~cmd.bank][s_idx] <= q;
    end
  end

  assign nv = zero_r ? '0 : vrd_r;

  // Discounted next value, rounded
  assign gsum = prod_r + PW'(32768);
  assign g    = $signed(gsum[PW-1:16]);

  always_comb begin
    inner_pre = (IPW'(ent.reward) <<< 4) + ((cmd.eval && ent.done) ? '0 : IPW'(g));
    if (inner_pre[IPW-1:VW-1] != {(IPW-VW+1){inner_pre[IPW-1]}}) begin
      inner_sat = {inner_pre[IPW-1], {(VW-1){~inner_pre[IPW-1]}}};
    end else begin
      inner_sat = inner_pre[VW-1:0];
    end
  end

  assign rsum = frac_r + PW'(32768);
  assign term = ACW'($signed(rsum[PW-1:16])) + (pint_r ? ACW'(inner_r) : '0);

  always_comb begin
    if (acc_r[ACW-1:VW-1] != {(ACW-VW+1){acc_r[ACW-1]}}) begin
      q = {acc_r[ACW-1], {(VW-1){~acc_r[ACW-1]}}};
    end else begin
      q = acc_r[VW-1:0];
    end
  end

  assign diff = (VW+1)'(q) - (VW+1)'(nv);
  assign absd = diff[VW] ? (VW+1)'(-diff) : diff;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MUL:   prod_r  <= $signed({1'b0, discount}) * nv;
      OP_INNER: inner_r <= inner_sat;
      OP_PMUL: begin
        frac_r <= inner_r * $signed({1'b0, ent.prob[15:0]});
        pint_r <= ent.prob[16];
      end
      OP_ACC:   acc_r   <= (cmd.slot0 ? '0 : acc_r) + term;
      OP_IMPROVE: begin
        if (a_idx == '0 || q > best_q_r) begin
          best_q_r <= q;
          best_a_r <= a_idx;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_r     <= '0;
      stable_r  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_STATES; i++) begin
        pol_r[i] <= '0;
      end
    end else begin
      out_valid <= 1'b0;
      case (cmd.op)
        OP_SOLVE_INIT: begin
          for (int i = 0; i < NUM_STATES; i++) begin
            pol_r[i] <= '0;
          end
        end
        OP_ROUND_INIT: begin
          stable_r <= 1'b1;
          big_r    <= '0;
        end
        OP_SWEEP:  big_r <= '0;
        OP_EWRITE: begin
          if (absd > big_r) begin
            big_r <= absd;
          end
        end
        OP_POLWRITE: begin
          pol_r[s_idx] <= best_a_r;
          if (best_a_r != pol_r[s_idx]) begin
            stable_r <= 1'b0;
          end
        end
        OP_EMIT:   out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_state       <= 4'(s_idx);
      out_best_action <= 2'(pol_r[s_idx]);
      out_stable      <= stable_r;
      out_last        <= cmd.last;
    end
  end

  assign status = '{big_gt_tol: (big_r > (VW+1)'(tolerance)), stable: stable_r};

endmodule
`default_nettype wire

// File: sv/mdp_pi_ctrl.sv
`default_nettype none
module mdp_pi_ctrl #(
  parameter int NUM_STATES   = 16,
  parameter int NUM_ACTIONS  = 4,
  parameter int NUM_OUTCOMES = 3
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic                               in_command,
  input  wire logic [$clog2(NUM_STATES+1)-1:0]    used,
  input  wire logic [15:0]                        max_sweeps,
  input  wire logic [7:0]                         max_rounds,
  input  wire mdp_pi_pkg::dp_status_t             status,
  output logic                                    busy,
  output mdp_pi_pkg::dp_cmd_t                     cmd,
  output logic [$clog2(NUM_STATES)-1:0]           s_idx,
  output logic [$clog2(NUM_ACTIONS)-1:0]          a_idx,
  output logic [((NUM_OUTCOMES > 1) ? $clog2(NUM_OUTCOMES) : 1)-1:0] o_idx
);
  import mdp_pi_pkg::*;

  localparam int SW = $clog2(NUM_STATES);
  localparam int AW = $clog2(NUM_ACTIONS);
  localparam int OW = (NUM_OUTCOMES > 1) ? $clog2(NUM_OUTCOMES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_RINIT, S_TREAD, S_VREAD, S_MUL, S_INNER, S_PMUL, S_ACC,
    S_PREAD, S_EWRITE, S_SWEEP, S_IMP, S_POLW, S_ROUND, S_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [OW-1:0] o_r, o_nxt;
  logic [15:0]   sweep_r, sweep_nxt;
  logic [7:0]    round_r, round_nxt;
  logic          bank_r, bank_nxt;
  logic          first_r, first_nxt;
  logic          eval_r, eval_nxt;

  logic          s_last, a_last, o_last;
  logic [15:0]   sweep_cap;
  logic [7:0]    round_cap;
  logic          more_sweeps, more_rounds;

  assign s_last = (32'(s_r) + 32'd1) == 32'(used);
  assign a_last = 32'(a_r) == NUM_ACTIONS - 1;
  assign o_last = 32'(o_r) == NUM_OUTCOMES - 1;

  assign sweep_cap   = (max_sweeps == '0) ? 16'd1 : max_sweeps;
  assign round_cap   = (max_rounds == '0) ? 8'd1 : max_rounds;
  assign more_sweeps = status.big_gt_tol && ((17'(sweep_r) + 17'd1) < 17'(sweep_cap));
  assign more_rounds = !status.stable && ((9'(round_r) + 9'd1) < 9'(round_cap));

  always_comb begin
    state_nxt = state_r;
    s_nxt     = s_r;
    a_nxt     = a_r;
    o_nxt     = o_r;
    sweep_nxt = sweep_r;
    round_nxt = round_r;
    bank_nxt  = bank_r;
    first_nxt = first_r;
    eval_nxt  = eval_r;
    cmd.op    = OP_NONE;
    cmd.eval  = eval_r;
    cmd.first = first_r;
    cmd.bank  = bank_r;
    cmd.slot0 = (o_r == '0);
    cmd.last  = s_last;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_command) begin
            state_nxt = S_INIT;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_INIT: begin
        cmd.op    = OP_SOLVE_INIT;
        round_nxt = '0;
        state_nxt = S_RINIT;
      end
      S_RINIT: begin
        cmd.op    = OP_ROUND_INIT;
        first_nxt = 1'b1;
        sweep_nxt = '0;
        s_nxt     = '0;
        a_nxt     = '0;
        o_nxt     = '0;
        eval_nxt  = 1'b1;
        state_nxt = S_TREAD;
      end
      S_TREAD: begin
        cmd.op    = OP_TREAD;
        state_nxt = S_VREAD;
      end
      S_VREAD: begin
        cmd.op    = OP_VREAD;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_INNER;
      end
      S_INNER: begin
        cmd.op    = OP_INNER;
        state_nxt = S_PMUL;
      end
      S_PMUL: begin
        cmd.op    = OP_PMUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (!o_last) begin
          o_nxt     = o_r + OW'(1);
          state_nxt = S_TREAD;
        end else begin
          o_nxt     = '0;
          state_nxt = eval_r ? S_PREAD : S_IMP;
        end
      end
      S_PREAD: begin
        cmd.op    = OP_PREAD;
        state_nxt = S_EWRITE;
      end
      S_EWRITE: begin
        cmd.op = OP_EWRITE;
        if (s_last) begin
          state_nxt = S_SWEEP;
        end else begin
          s_nxt     = s_r + SW'(1);
          state_nxt = S_TREAD;
        end
      end
      S_SWEEP: begin
        // Flip banks; stop on tolerance or cap, then improve
        cmd.op    = OP_SWEEP;
        bank_nxt  = ~bank_r;
        first_nxt = 1'b0;
        sweep_nxt = sweep_r + 16'd1;
        s_nxt     = '0;
        a_nxt     = '0;
        eval_nxt  = more_sweeps;
        state_nxt = S_TREAD;
      end
      S_IMP: begin
        cmd.op = OP_IMPROVE;
        if (a_last) begin
          state_nxt = S_POLW;
        end else begin
          a_nxt     = a_r + AW'(1);
          state_nxt = S_TREAD;
        end
      end
      S_POLW: begin
        cmd.op = OP_POLWRITE;
        a_nxt  = '0;
        if (s_last) begin
          state_nxt = S_ROUND;
        end else begin
          s_nxt     = s_r + SW'(1);
          state_nxt = S_TREAD;
        end
      end
      S_ROUND: begin
        round_nxt = round_r + 8'd1;
        s_nxt     = '0;
        state_nxt = more_rounds ? S_RINIT : S_EMIT;
      end
      S_EMIT: begin
        cmd.op = OP_EMIT;
        if (s_last) begin
          state_nxt = S_IDLE;
        end else begin
          s_nxt = s_r + SW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      s_r     <= '0;
      a_r     <= '0;
      o_r     <= '0;
      sweep_r <= '0;
      round_r <= '0;
      bank_r  <= 1'b0;
      first_r <= 1'b1;
      eval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s_r     <= s_nxt;
      a_r     <= a_nxt;
      o_r     <= o_nxt;
      sweep_r <= sweep_nxt;
      round_r <= round_nxt;
      bank_r  <= bank_nxt;
      first_r <= first_nxt;
      eval_r  <= eval_nxt;
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign s_idx = s_r;
  assign a_idx = a_r;
  assign o_idx = o_r;

endmodule
`default_nettype wire

// File: sv/mdp_policy_iteration.sv
`default_nettype none
// Tabular MDP policy iteration engine. A beat with in_command low loads one
// transition outcome into the table while staying idle, so loads may stream
// back to back. A beat with in_command high solves: busy rises after the
// accepting edge and drops in the cycle that shows the final result. The solve
// runs policy rounds from an all-zero policy; each round evaluates with Jacobi
// sweeps (values restart at zero) and then improves every state in use.
// Results come out one per cycle on out_valid, state 0 first, with out_last on
// the final one; there is no backpressure, so the receiver must take every
// beat as it appears. All arithmetic runs through one shared multiply-
// accumulate datapath that takes each outcome slot through table read, value
// read, discount multiply, inner term, probability multiply and accumulate.
// Sweeps per round and rounds per solve are bounded by max_sweeps and
// max_rounds.
// Configuration must be written only while busy is low. The table's entries
// read as zero until loaded; a reset clears them at once.
module mdp_policy_iteration #(
  parameter int NUM_STATES   = mdp_pi_pkg::NUM_STATES_DEF,
  parameter int NUM_ACTIONS  = mdp_pi_pkg::NUM_ACTIONS_DEF,
  parameter int NUM_OUTCOMES = mdp_pi_pkg::NUM_OUTCOMES_DEF,
  parameter int VALUE_WIDTH  = mdp_pi_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_command,
  input  wire logic [3:0]                     in_state_index,
  input  wire logic [1:0]                     in_action_index,
  input  wire logic [1:0]                     in_outcome_slot,
  input  wire logic [3:0]                     in_next_state,
  input  wire logic signed [15:0]             in_reward,
  input  wire logic [16:0]                    in_probability,
  input  wire logic                           in_terminal,
  output logic                                out_valid,
  output logic [3:0]                          out_state,
  output logic [1:0]                          out_best_action,
  output logic                                out_stable,
  output logic                                out_last,
  input  wire logic                           cfg_we,
  input  wire logic [mdp_pi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                    cfg_wdata
);
  import mdp_pi_pkg::*;

  localparam int SW = $clog2(NUM_STATES);
  localparam int AW = $clog2(NUM_ACTIONS);
  localparam int OW = (NUM_OUTCOMES > 1) ? $clog2(NUM_OUTCOMES) : 1;
  localparam int UW = $clog2(NUM_STATES+1);

  logic [15:0]   discount_r;
  logic [15:0]   tolerance_r;
  logic [15:0]   max_sweeps_r;
  logic [7:0]    max_rounds_r;
  logic [4:0]    states_in_use_r;
  logic [UW-1:0] used;

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [SW-1:0] s_idx;
  logic [AW-1:0] a_idx;
  logic [OW-1:0] o_idx;

  // Configuration registers; indices past the map drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discount_r      <= DISCOUNT_RST;
      tolerance_r     <= TOLERANCE_RST;
      max_sweeps_r    <= MAX_SWEEPS_RST;
      max_rounds_r    <= MAX_ROUNDS_RST;
      states_in_use_r <= STATES_IN_USE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISCOUNT:      discount_r      <= cfg_wdata;
        REG_TOLERANCE:     tolerance_r     <= cfg_wdata;
        REG_MAX_SWEEPS:    max_sweeps_r    <= cfg_wdata;
        REG_MAX_ROUNDS:    max_rounds_r    <= cfg_wdata[7:0];
        REG_STATES_IN_USE: states_in_use_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // Clamp states in use: zero acts as one, too many saturates
  always_comb begin
    if (states_in_use_r == '0) begin
      used = UW'(1);
    end else if (32'(states_in_use_r) > NUM_STATES) begin
      used = UW'(NUM_STATES);
    end else begin
      used = UW'(states_in_use_r);
    end
  end

  mdp_pi_ctrl #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS),
    .NUM_OUTCOMES(NUM_OUTCOMES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_command(in_command),
    .used      (used),
    .max_sweeps(max_sweeps_r),
    .max_rounds(max_rounds_r),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd),
    .s_idx     (s_idx),
    .a_idx     (a_idx),
    .o_idx     (o_idx)
  );

  mdp_pi_dp #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS),
    .NUM_OUTCOMES(NUM_OUTCOMES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .s_idx          (s_idx),
    .a_idx          (a_idx),
    .o_idx          (o_idx),
    .used           (used),
    .discount       (discount_r),
    .tolerance      (tolerance_r),
    .in_state_index (in_state_index),
    .in_action_index(in_action_index),
    .in_outcome_slot(in_outcome_slot),
    .in_next_state  (in_next_state),
    .in_reward      (in_reward),
    .in_probability (in_probability),
    .in_terminal    (in_terminal),
    .status         (status),
    .out_valid      (out_valid),
    .out_state      (out_state),
    .out_best_action(out_best_action),
    .out_stable     (out_stable),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

// File: sv/mdp_pi_chk.sv
`default_nettype none
module mdp_pi_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       in_command,
  input wire logic       out_valid,
  input wire logic [3:0] out_state,
  input wire logic       out_stable,
  input wire logic       out_last
);

  // A solve beat makes the block busy
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_command |=> busy)
    else $error("solve beat did not raise busy");

  // Results of a solve come out on consecutive cycles until the last one
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("result burst broken before last");

  a_state_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_state == 4'($past(out_state) + 4'd1))
    else $error("result states out of order");

  a_stable_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_stable == $past(out_stable))
    else $error("stable flag changed within a solve");

endmodule

bind mdp_policy_iteration mdp_pi_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_command(in_command),
  .out_valid (out_valid),
  .out_state (out_state),
  .out_stable(out_stable),
  .out_last  (out_last)
);
`default_nettype wire
